// ----- rtl/mh2_pkg.sv -----
// shared constants, codes and types for the murmur2 string hash block
package mh2_pkg;

  // hash constants
  localparam int unsigned HashW = 32;
  localparam logic [HashW-1:0] MixM = 32'h5bd1e995;
  localparam int unsigned ShiftK = 24;
  localparam int unsigned ShiftFin1 = 13;
  localparam int unsigned ShiftFin2 = 15;

  // configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic RegHashSeed = 1'b0;  // register select bit paddr[2]

  // controller states
  typedef enum logic [2:0] {
    StIdle,
    StMixK1,
    StMixK2,
    StMixH,
    StTail,
    StFin1,
    StFin2
  } mh2_state_e;

  // datapath operations
  typedef enum logic [2:0] {
    OpNone,
    OpLoad,
    OpMixK1,
    OpMixK2,
    OpMixH,
    OpTail,
    OpFin1,
    OpFin2
  } mh2_op_e;

  typedef struct packed {
    mh2_op_e op;
  } mh2_cmd_t;

  typedef struct packed {
    logic word_done;  // incoming byte completes a four-byte word
    logic tail_nz;    // tail bytes remain after the incoming beat
  } mh2_stat_t;

endpackage

// ----- rtl/mh2_stream_if.sv -----
// stream interfaces for message bytes in and hash results out
interface mh2_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_length;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        first_item;
  logic        last_item;

  modport source (output valid, msg_length, data_byte, byte_present, first_item,
                  last_item, input ready);
  modport sink (input valid, msg_length, data_byte, byte_present, first_item,
                last_item, output ready);
endinterface

interface mh2_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

// ----- rtl/mh2_ctrl.sv -----
// sequencer for the shared multiplier and the result register handshake
module mh2_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  mh2_pkg::mh2_stat_t stat_i,
  output mh2_pkg::mh2_cmd_t  cmd_o
);

  mh2_pkg::mh2_state_e state_q, state_d;
  logic last_q, last_d;
  logic out_valid_q, out_valid_d;

  // state and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mh2_pkg::StIdle;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = mh2_pkg::OpNone;
    unique case (state_q)
      mh2_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = mh2_pkg::OpLoad;
          last_d   = in_last_i;
          if (stat_i.word_done) begin
            state_d = mh2_pkg::StMixK1;
          end else if (in_last_i) begin
            state_d = stat_i.tail_nz ? mh2_pkg::StTail : mh2_pkg::StFin1;
          end
        end
      end
      mh2_pkg::StMixK1: begin
        cmd_o.op = mh2_pkg::OpMixK1;
        state_d  = mh2_pkg::StMixK2;
      end
      mh2_pkg::StMixK2: begin
        cmd_o.op = mh2_pkg::OpMixK2;
        state_d  = mh2_pkg::StMixH;
      end
      mh2_pkg::StMixH: begin
        cmd_o.op = mh2_pkg::OpMixH;
        // word just absorbed, so no tail bytes remain
        state_d  = last_q ? mh2_pkg::StFin1 : mh2_pkg::StIdle;
      end
      mh2_pkg::StTail: begin
        cmd_o.op = mh2_pkg::OpTail;
        state_d  = mh2_pkg::StFin1;
      end
      mh2_pkg::StFin1: begin
        cmd_o.op = mh2_pkg::OpFin1;
        state_d  = mh2_pkg::StFin2;
      end
      mh2_pkg::StFin2: begin
        // wait for the result register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = mh2_pkg::OpFin2;
          out_valid_d = 1'b1;
          state_d     = mh2_pkg::StIdle;
        end
      end
      default: state_d = mh2_pkg::StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/mh2_dp.sv -----
// hash datapath: word collector, running hash and one shared constant multiplier
module mh2_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       seed_i,
  input  logic [31:0]       msg_length_i,
  input  logic [7:0]        data_byte_i,
  input  logic              byte_present_i,
  input  logic              first_item_i,
  input  mh2_pkg::mh2_cmd_t  cmd_i,
  output mh2_pkg::mh2_stat_t stat_o,
  output logic [31:0]       hash_value_o
);

  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  logic [23:0] pw_q, pw_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] hash_q, hash_d;

  logic [31:0] h_start;
  logic [23:0] pw_start;
  logic [1:0]  cnt_start;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic [31:0] fin;

  // start of message and word collector view of the incoming beat
  assign h_start   = first_item_i ? (seed_i ^ msg_length_i) : h_q;
  assign pw_start  = first_item_i ? 24'd0 : pw_q;
  assign cnt_start = first_item_i ? 2'd0 : cnt_q;

  assign stat_o.word_done = byte_present_i && (cnt_start == 2'd3);
  assign stat_o.tail_nz   = byte_present_i ? (cnt_start != 2'd3) : (cnt_start != 2'd0);

  // shared multiplier operand select
  always_comb begin
    unique case (cmd_i.op)
      mh2_pkg::OpMixK2: mul_a = k_q ^ (k_q >> mh2_pkg::ShiftK);
      mh2_pkg::OpMixH:  mul_a = h_q;
      mh2_pkg::OpTail:  mul_a = h_q ^ {8'd0, pw_q};
      mh2_pkg::OpFin1:  mul_a = h_q ^ (h_q >> mh2_pkg::ShiftFin1);
      default:          mul_a = k_q;
    endcase
  end

  assign prod = mul_a * mh2_pkg::MixM;
  assign fin  = h_q ^ (h_q >> mh2_pkg::ShiftFin2);

  // register updates per operation
  always_comb begin
    h_d    = h_q;
    k_d    = k_q;
    pw_d   = pw_q;
    cnt_d  = cnt_q;
    hash_d = hash_q;
    unique case (cmd_i.op)
      mh2_pkg::OpLoad: begin
        h_d   = h_start;
        pw_d  = pw_start;
        cnt_d = cnt_start;
        if (byte_present_i) begin
          if (cnt_start == 2'd3) begin
            k_d   = {data_byte_i, pw_start};
            pw_d  = 24'd0;
            cnt_d = 2'd0;
          end else begin
            pw_d  = pw_start | (24'(data_byte_i) << {cnt_start, 3'b000});
            cnt_d = cnt_start + 2'd1;
          end
        end
      end
      mh2_pkg::OpMixK1,
      mh2_pkg::OpMixK2: k_d = prod;
      mh2_pkg::OpMixH:  h_d = prod ^ k_q;
      mh2_pkg::OpTail: begin
        h_d   = prod;
        pw_d  = 24'd0;
        cnt_d = 2'd0;
      end
      mh2_pkg::OpFin1:  h_d = prod;
      mh2_pkg::OpFin2: begin
        h_d    = fin;
        hash_d = fin;
        pw_d   = 24'd0;
        cnt_d  = 2'd0;
      end
      default: ;
    endcase
  end

  // hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= 32'd0;
      pw_q  <= 24'd0;
      cnt_q <= 2'd0;
    end else begin
      h_q   <= h_d;
      pw_q  <= pw_d;
      cnt_q <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    hash_q <= hash_d;
  end

  assign hash_value_o = hash_q;

endmodule

// ----- rtl/murmur2_string_hash_top.sv -----
// top level of the murmur2 string hash block with its seed register
//
// Message bytes arrive one per beat on msg_i. A beat with first_item set
// loads the running hash with the seed XOR msg_length; byte_present marks a
// real byte. Bytes gather little-endian into 32-bit words; a beat with
// last_item set folds in the tail, runs the avalanche and hands one 32-bit
// hash to hash_o.
// A beat that neither completes a word nor is the last keeps the block ready;
// a beat that completes a word stalls the input while the single constant
// multiplier runs the three word multiplies one after another. A last beat
// adds the tail multiply (only when 1 to 3 bytes are left) and the avalanche,
// and the result is valid on hash_o the cycle after. The result sits in an
// output register: while it waits, further beats of the next message are
// taken; only the final step of the next hash stalls until the receiver takes
// the pending result. The seed is written through the APB port at address 0;
// the user must write it only while the block is idle, which the block does
// not enforce. Reset clears the seed, the running hash and the word collector.
module murmur2_string_hash_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mh2_in_if.sink                        msg_i,
  mh2_out_if.source                     hash_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mh2_pkg::CfgAddrW-1:0]  paddr,
  input  logic [mh2_pkg::CfgDataW-1:0]  pwdata,
  output logic [mh2_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  logic [31:0] seed_q, seed_d;
  logic        cfg_wr;
  mh2_pkg::mh2_cmd_t  cmd;
  mh2_pkg::mh2_stat_t stat;

  // seed register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == mh2_pkg::RegHashSeed);
  assign seed_d = cfg_wr ? pwdata : seed_q;
  assign prdata = (paddr[2] == mh2_pkg::RegHashSeed) ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 32'd0;
    end else begin
      seed_q <= seed_d;
    end
  end

  // controller
  mh2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (msg_i.valid),
    .in_last_i   (msg_i.last_item),
    .in_ready_o  (msg_i.ready),
    .out_ready_i (hash_o.ready),
    .out_valid_o (hash_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  mh2_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_i         (seed_q),
    .msg_length_i   (msg_i.msg_length),
    .data_byte_i    (msg_i.data_byte),
    .byte_present_i (msg_i.byte_present),
    .first_item_i   (msg_i.first_item),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .hash_value_o   (hash_o.hash_value)
  );

  // a plain byte beat leaves the block ready for the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_i.valid && msg_i.ready && !msg_i.last_item && !stat.word_done |=> msg_i.ready)
    else $error("not ready after a plain byte beat");

  // a completed word keeps the multiplier busy through MixK1, MixK2 and MixH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_i.valid && msg_i.ready && stat.word_done
      |=> !msg_i.ready ##1 !msg_i.ready ##1 !msg_i.ready)
    else $error("word mix shorter than three cycles");

  // a result only appears out of the final avalanche step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hash_o.valid) |-> !$past(msg_i.ready))
    else $error("result raised while idle");

  // the multiplier is only driven while no beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_i.ready |-> (cmd.op == mh2_pkg::OpNone || cmd.op == mh2_pkg::OpLoad))
    else $error("datapath busy while accepting");

endmodule

// ----- test/testbench.sv -----
// testbench for the murmur2 string hash block: byte messages checked against an in-bench hash
module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned IdlePct = 8;
  localparam int unsigned PhaseBeats = 290;
  localparam int unsigned HoldCycles = 400;
  localparam logic [mh2_pkg::CfgAddrW-1:0] SeedAddr = 3'd0;
  localparam logic [mh2_pkg::CfgAddrW-1:0] SpareAddr = 3'd4;

  typedef enum int unsigned {
    BytesRandom,
    BytesOnes,
    BytesZeros
  } byte_fill_e;

  typedef struct packed {
    logic [31:0] msg_length;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        first_item;
    logic        last_item;
  } beat_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mh2_pkg::CfgAddrW-1:0] paddr;
  logic [mh2_pkg::CfgDataW-1:0] pwdata;
  logic [mh2_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  mh2_in_if  msg_if ();
  mh2_out_if hash_if ();

  murmur2_string_hash_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .msg_i   (msg_if),
    .hash_o  (hash_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // hash state as the block should hold it
  logic [31:0] seed_reg;
  logic [31:0] run_hash;
  logic [23:0] part_word;
  logic [1:0]  word_fill;
  logic [31:0] pending_hashes[$];

  int unsigned err_count;
  int unsigned beats_sent;
  int unsigned cycle_count;
  int unsigned hold_req;
  bit          no_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at cycle %0d: %s, want %08h got %08h", cycle_count, what, want, got);
    err_count++;
  endtask

  // one accepted beat through the hash: start, byte, then end
  task automatic murmur_step(input beat_t b);
    logic [31:0] k;
    logic [31:0] h;
    if (b.first_item) begin
      run_hash  = seed_reg ^ b.msg_length;
      part_word = '0;
      word_fill = '0;
    end
    if (b.byte_present) begin
      if (word_fill == 2'd3) begin
        k = {b.data_byte, part_word};
        k = k * mh2_pkg::MixM;
        k = k ^ (k >> mh2_pkg::ShiftK);
        k = k * mh2_pkg::MixM;
        run_hash  = (run_hash * mh2_pkg::MixM) ^ k;
        part_word = '0;
        word_fill = '0;
      end else begin
        part_word[8*word_fill +: 8] = b.data_byte;
        word_fill = word_fill + 2'd1;
      end
    end
    if (b.last_item) begin
      h = run_hash;
      // uncollected bytes of part_word are zero, so one xor covers the fall-through
      if (word_fill != 2'd0) begin
        h = h ^ {8'h00, part_word};
        h = h * mh2_pkg::MixM;
      end
      h = h ^ (h >> mh2_pkg::ShiftFin1);
      h = h * mh2_pkg::MixM;
      h = h ^ (h >> mh2_pkg::ShiftFin2);
      run_hash  = h;
      part_word = '0;
      word_fill = '0;
      pending_hashes.push_back(h);
    end
  endtask

  // offer one beat, entered and left at a falling edge
  task automatic push_beat(input beat_t b);
    if (!no_idle && $urandom_range(99) < IdlePct) begin
      msg_if.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    msg_if.valid        = 1'b1;
    msg_if.msg_length   = b.msg_length;
    msg_if.data_byte    = b.data_byte;
    msg_if.byte_present = b.byte_present;
    msg_if.first_item   = b.first_item;
    msg_if.last_item    = b.last_item;
    @(posedge clk_i);
    while (!msg_if.ready) @(posedge clk_i);
    murmur_step(b);
    if (b.byte_present || b.first_item || b.last_item) beats_sent++;
    @(negedge clk_i);
  endtask

  // one message: optional empty header and terminator, stray empty beats inside
  task automatic send_message(input int unsigned n_bytes, input logic [31:0] len_field,
                              input bit open_empty, input bit close_empty,
                              input bit no_start, input bit no_end,
                              input byte_fill_e fill, input int unsigned noise_pct);
    int unsigned n_beats;
    int          idx;
    beat_t       b;
    n_beats = n_bytes + open_empty + close_empty;
    if (n_beats == 0) n_beats = 1;
    for (int unsigned i = 0; i < n_beats; i++) begin
      if (i != 0 && $urandom_range(99) < noise_pct) begin
        b.msg_length   = $urandom();
        b.data_byte    = 8'($urandom());
        b.byte_present = 1'b0;
        b.first_item   = 1'b0;
        b.last_item    = 1'b0;
        push_beat(b);
      end
      idx = int'(i) - int'(open_empty);
      b.msg_length   = (i == 0) ? len_field : $urandom();
      b.byte_present = (idx >= 0) && (idx < int'(n_bytes));
      b.first_item   = (i == 0) && !no_start;
      b.last_item    = (i == n_beats - 1) && !no_end;
      case (fill)
        BytesOnes:  b.data_byte = 8'hFF;
        BytesZeros: b.data_byte = 8'h00;
        default:    b.data_byte = 8'($urandom());
      endcase
      push_beat(b);
    end
  endtask

  // sender pauses until every hash has come, then lets the block settle
  task automatic drain_results();
    msg_if.valid = 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [mh2_pkg::CfgAddrW-1:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == SeedAddr) seed_reg = data;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read_check(input logic [mh2_pkg::CfgAddrW-1:0] addr,
                                input logic [31:0] want);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) report_mismatch("seed read back", want, prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // beats with no start flag run on from the hash left by reset or the last message
  task automatic test_reset_state();
    apb_read_check(SeedAddr, 32'h0);
    send_message(0, 32'h0, 1'b0, 1'b0, 1'b1, 1'b0, BytesRandom, 0);
    send_message(1, 32'h0, 1'b0, 1'b0, 1'b1, 1'b0, BytesOnes, 0);
    drain_results();
  endtask

  // seed write, read back, and a write to the spare address that must change nothing
  task automatic test_seed_register();
    apb_write(SeedAddr, 32'hFFFF_FFFF);
    apb_read_check(SeedAddr, 32'hFFFF_FFFF);
    apb_write(SpareAddr, 32'h1234_5678);
    apb_read_check(SeedAddr, 32'hFFFF_FFFF);
    send_message(0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, BytesRandom, 0);
    send_message(1, 32'h1, 1'b0, 1'b0, 1'b0, 1'b0, BytesOnes, 0);
    drain_results();
  endtask

  // each tail size, a full word, empty header and terminator, a wrong length
  task automatic test_tail_lengths();
    for (int unsigned n = 1; n <= 4; n++) begin
      send_message(n, n, 1'b0, 1'b0, 1'b0, 1'b0, BytesOnes, 0);
    end
    send_message(4, 32'h4, 1'b0, 1'b0, 1'b0, 1'b0, BytesZeros, 0);
    send_message(2, 32'h2, 1'b1, 1'b1, 1'b0, 1'b0, BytesRandom, 0);
    send_message(3, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, BytesRandom, 0);
    drain_results();
  endtask

  // receiver holds off while short messages keep coming, so the input stalls
  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_req = HoldCycles;
    for (int i = 0; i < 30; i++) begin
      send_message($urandom_range(0, 3), $urandom(), 1'b0, 1'b0, 1'b0, 1'b0, BytesRandom, 0);
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned stop_at;
    int unsigned n;
    int unsigned pick;
    logic [31:0] len_field;
    byte_fill_e  fill;
    stop_at = beats_sent + target;
    while (beats_sent < stop_at) begin
      // mostly short messages, now and then a long one
      pick = $urandom_range(99);
      if (pick < 80) n = $urandom_range(0, 12);
      else if (pick < 96) n = $urandom_range(13, 40);
      else n = $urandom_range(41, 64);
      pick = $urandom_range(99);
      if (pick < 85) len_field = n;
      else if (pick < 90) len_field = 32'hFFFF_FFFF;
      else if (pick < 92) len_field = 32'h0;
      else len_field = $urandom();
      pick = $urandom_range(99);
      if (pick < 90) fill = BytesRandom;
      else if (pick < 95) fill = BytesOnes;
      else fill = BytesZeros;
      send_message(n, len_field, $urandom_range(99) < 10, $urandom_range(99) < 15,
                   $urandom_range(99) < 4, $urandom_range(99) < 5, fill, 5);
    end
  endtask

  // random messages under several seeds, one phase without any idling
  task automatic test_random_traffic();
    logic [31:0] seeds[5];
    seeds[0] = 32'h0;
    seeds[1] = 32'hFFFF_FFFF;
    seeds[2] = $urandom();
    seeds[3] = 32'h8000_0000;
    seeds[4] = $urandom();
    for (int i = 0; i < 5; i++) begin
      apb_write(SeedAddr, seeds[i]);
      apb_read_check(SeedAddr, seeds[i]);
      no_idle = (i == 2);
      random_phase(PhaseBeats);
      no_idle = 1'b0;
      drain_results();
    end
  endtask

  // hash receiver with random stalls and requested hold-offs
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    hash_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hash_if.ready = 1'b0;
        hold_left--;
      end else begin
        hash_if.ready = no_idle || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // compare each hash beat with the oldest expected hash
  always @(posedge clk_i) begin
    if (rst_ni && hash_if.valid && hash_if.ready) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch("hash with none expected", 32'h0, hash_if.hash_value);
      end else if (hash_if.hash_value !== pending_hashes[0]) begin
        report_mismatch("hash_value", pending_hashes[0], hash_if.hash_value);
        void'(pending_hashes.pop_front());
      end else begin
        void'(pending_hashes.pop_front());
      end
    end
  end

  // stimulus
  initial begin
    err_count           = 0;
    beats_sent          = 0;
    hold_req            = 0;
    no_idle             = 1'b0;
    seed_reg            = '0;
    run_hash            = '0;
    part_word           = '0;
    word_fill           = '0;
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    msg_if.valid        = 1'b0;
    msg_if.msg_length   = '0;
    msg_if.data_byte    = '0;
    msg_if.byte_present = 1'b0;
    msg_if.first_item   = 1'b0;
    msg_if.last_item    = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_seed_register();
    test_tail_lengths();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mh2_pkg.sv
rtl/mh2_stream_if.sv
rtl/mh2_ctrl.sv
rtl/mh2_dp.sv
rtl/murmur2_string_hash_top.sv
test/testbench.sv
